@@ rtl/core/crfe_pkg.sv @@
// Shared types, codes and constants of the clipped rectangle fill engine.
`timescale 1ns / 1ps

package crfe_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int COORD_W    = 16;  // signed rectangle corner
	localparam int SIZE_W     = 15;  // rectangle width and height
	localparam int POS_W      = 8;   // read position
	localparam int COLOR_W    = 32;
	localparam int SIZE_REG_W = 9;   // width and height registers
	localparam int CLIP_W     = 18;  // corner plus size without overflow
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [SIZE_REG_W-1:0] RESET_SIZE = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

	typedef enum logic [1:0] {
		KIND_FILL  = 2'd0,
		KIND_GRID  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SETUP,
		ST_FILL,
		ST_RD_MEM,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic fill_step;
		logic read_mem;
		logic out_load;
		logic sweep_start;
		logic sweep_step;
	} dp_cmd_t;

	typedef struct packed {
		logic resize_wr;
		logic span_ok;
		logic is_read;
		logic fill_last;
		logic sweep_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/crfe_ctrl.sv @@
// Sequencer of the fill engine: request intake, fill walk, read and store sweep.
`timescale 1ns / 1ps

module crfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crfe_pkg::kind_t   kind,
	input  logic              cfg_valid,
	input  crfe_pkg::dp_stat_t stat,
	output crfe_pkg::dp_cmd_t  cmd
);
	import crfe_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// a register write goes ahead of a request in the same cycle
				in_ready = !cfg_valid;
				if (in_valid && !cfg_valid) begin
					cmd.load = 1'b1;
					if (kind == KIND_CLEAR) begin
						cmd.sweep_start = 1'b1;
						state_d         = ST_SWEEP;
					end else begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				if (stat.is_read) begin
					state_d = ST_RD_MEM;
				end else if (stat.span_ok) begin
					state_d = ST_FILL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_MEM: begin
				cmd.read_mem = 1'b1;
				state_d      = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// resize refills the whole store, restarting any sweep under way
		if (stat.resize_wr) begin
			cmd.sweep_start = 1'b1;
			state_d         = ST_SWEEP;
		end
	end

endmodule

@@ rtl/core/crfe_dp.sv @@
// Datapath of the fill engine: registers, clipping, address walk, frame store, output.
`timescale 1ns / 1ps

module crfe_dp #(
	parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  crfe_pkg::kind_t                       kind,
	input  logic signed [crfe_pkg::COORD_W-1:0]   rect_x,
	input  logic signed [crfe_pkg::COORD_W-1:0]   rect_y,
	input  logic [crfe_pkg::SIZE_W-1:0]           rect_w,
	input  logic [crfe_pkg::SIZE_W-1:0]           rect_h,
	input  logic [crfe_pkg::COLOR_W-1:0]          fill_color,
	input  logic [crfe_pkg::POS_W-1:0]            read_x,
	input  logic [crfe_pkg::POS_W-1:0]            read_y,
	input  logic                                  cfg_valid,
	input  logic [crfe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [crfe_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [crfe_pkg::COLOR_W-1:0]          pixel_value,
	input  crfe_pkg::dp_cmd_t                     cmd,
	output crfe_pkg::dp_stat_t                    stat
);
	import crfe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int MW    = (YW > POS_W) ? YW : POS_W;
	localparam int PW    = MW + XW;

	// configuration registers
	logic [SIZE_REG_W-1:0] width_q, height_q;
	logic [COLOR_W-1:0]    bg_q;

	// request registers
	logic [XW-1:0]      xs_q, xe_m1_q, col_q;
	logic [YW-1:0]      ys_q, ye_m1_q, row_q;
	logic [POS_W-1:0]   rx_q, ry_q;
	logic [COLOR_W-1:0] color_q;
	logic               span_ok_q, is_read_q, inside_q;
	logic [AW-1:0]      base_q;

	// sweep, store and output
	logic [AW-1:0]      sweep_addr_q;
	logic [COLOR_W-1:0] sweep_color_q;
	logic [COLOR_W-1:0] rdata_q;
	logic               out_valid_q;
	logic [COLOR_W-1:0] pixel_q;
	logic [COLOR_W-1:0] mem [DEPTH];

	logic [XW-1:0] fw;
	logic [YW-1:0] fh;

	logic signed [CLIP_W-1:0] x_e, y_e, w_e, h_e, fw_e, fh_e, trim_e;
	logic signed [CLIP_W-1:0] xr, yb, xs_c, ys_c, xe_c, ye_c;
	logic                     x_ok, y_ok, inside_c;

	logic [MW-1:0] mul_a;
	logic [PW-1:0] prod;
	logic [AW:0]   fill_sum, rd_sum;
	logic [AW-1:0] fill_addr, rd_addr, wr_addr;
	logic [COLOR_W-1:0] wr_data;
	logic          wr_en, col_end;

	// in-use size saturates at the store geometry
	always_comb begin
		fw = (int'(width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_q);
		fh = (int'(height_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIZE;
			height_q <= RESET_SIZE;
			bg_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:      width_q  <= cfg_data[SIZE_REG_W-1:0];
				REG_HEIGHT:     height_q <= cfg_data[SIZE_REG_W-1:0];
				REG_BACKGROUND: bg_q     <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// clip the rectangle against the in-use frame
	always_comb begin
		x_e    = {{(CLIP_W-COORD_W){rect_x[COORD_W-1]}}, rect_x};
		y_e    = {{(CLIP_W-COORD_W){rect_y[COORD_W-1]}}, rect_y};
		w_e    = {{(CLIP_W-SIZE_W){1'b0}}, rect_w};
		h_e    = {{(CLIP_W-SIZE_W){1'b0}}, rect_h};
		fw_e   = CLIP_W'(fw);
		fh_e   = CLIP_W'(fh);
		trim_e = CLIP_W'(kind == KIND_GRID);
		xr     = x_e + w_e;
		yb     = y_e + h_e;
		xs_c   = x_e[CLIP_W-1] ? '0 : x_e;
		ys_c   = y_e[CLIP_W-1] ? '0 : y_e;
		xe_c   = ((xr > fw_e) ? fw_e : xr) - trim_e;
		ye_c   = ((yb > fh_e) ? fh_e : yb) - trim_e;
		x_ok   = xs_c < xe_c;
		y_ok   = ys_c < ye_c;
		inside_c = (int'(read_x) < int'(fw)) && (int'(read_y) < int'(fh));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_ok_q <= 1'b0;
			is_read_q <= 1'b0;
			inside_q  <= 1'b0;
		end else if (cmd.load) begin
			span_ok_q <= x_ok && y_ok;
			is_read_q <= (kind == KIND_READ);
			inside_q  <= inside_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q    <= XW'(xs_c);
			ys_q    <= YW'(ys_c);
			xe_m1_q <= XW'(xe_c - 1);
			ye_m1_q <= YW'(ye_c - 1);
			rx_q    <= read_x;
			ry_q    <= read_y;
			color_q <= fill_color;
		end
	end

	// row base of the first row, or of the read row
	always_comb begin
		mul_a = is_read_q ? MW'(ry_q) : MW'(ys_q);
		prod  = PW'(mul_a) * PW'(fw);
	end

	assign col_end = (col_q == xe_m1_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			base_q <= prod[AW-1:0];
			col_q  <= xs_q;
			row_q  <= ys_q;
		end else if (cmd.fill_step) begin
			if (col_end) begin
				col_q  <= xs_q;
				row_q  <= row_q + 1'b1;
				base_q <= base_q + AW'(fw);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q  <= '0;
			sweep_color_q <= '0;
		end else if (cmd.sweep_start) begin
			sweep_addr_q  <= '0;
			sweep_color_q <= bg_q;
		end else if (cmd.sweep_step) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	always_comb begin
		fill_sum  = (AW+1)'(base_q) + (AW+1)'(col_q);
		rd_sum    = (AW+1)'(base_q) + (AW+1)'(rx_q);
		fill_addr = fill_sum[AW-1:0];
		rd_addr   = rd_sum[AW-1:0];
		wr_en     = cmd.sweep_step || cmd.fill_step;
		wr_addr   = cmd.sweep_step ? sweep_addr_q : fill_addr;
		wr_data   = cmd.sweep_step ? sweep_color_q : color_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.read_mem) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_q <= inside_q ? rdata_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;

	always_comb begin
		stat.resize_wr  = cfg_valid && (cfg_index inside {REG_WIDTH, REG_HEIGHT});
		stat.span_ok    = span_ok_q;
		stat.is_read    = is_read_q;
		stat.fill_last  = col_end && (row_q == ye_m1_q);
		stat.sweep_last = (sweep_addr_q == AW'(DEPTH - 1));
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

@@ rtl/core/clipped_rect_fill_engine_unit.sv @@
// Top level of the clipped rectangle fill engine: sequencer plus datapath.
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_ready    kind, rect_x, rect_y, rect_w, rect_h,
//                                             fill_color, read_x, read_y
//  out      result     out_valid / out_ready  pixel_value (read requests only)
//  cfg      write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Fill and grid requests pass a setup step, then write one pixel per cycle: the store
// has a single write port. A read passes setup, store read and output steps; a clear
// sweeps the whole store. After reset, and after every write of the width or height
// register, a sweep refills the whole store with the background color; in_ready stays
// low meanwhile. cfg_ready is always high. A pending result stalls only the next read,
// in its output step.
`timescale 1ns / 1ps

module clipped_rect_fill_engine_unit #(
	parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  crfe_pkg::kind_t                     kind,
	input  logic signed [crfe_pkg::COORD_W-1:0] rect_x,
	input  logic signed [crfe_pkg::COORD_W-1:0] rect_y,
	input  logic [crfe_pkg::SIZE_W-1:0]         rect_w,
	input  logic [crfe_pkg::SIZE_W-1:0]         rect_h,
	input  logic [crfe_pkg::COLOR_W-1:0]        fill_color,
	input  logic [crfe_pkg::POS_W-1:0]          read_x,
	input  logic [crfe_pkg::POS_W-1:0]          read_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [crfe_pkg::COLOR_W-1:0]        pixel_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crfe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import crfe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	crfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.cfg_valid(cfg_valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	crfe_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.fill_color (fill_color),
		.read_x     (read_x),
		.read_y     (read_y),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.pixel_value(pixel_value),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

@@ rtl/core/crfe_checker.sv @@
// Port-level checks of the fill engine, bound to its top level.
`timescale 1ns / 1ps

module crfe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [crfe_pkg::COLOR_W-1:0]    pixel_value,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [crfe_pkg::CFG_IDX_W-1:0]  cfg_index
);
	import crfe_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_value))
		else $error("result changed or dropped while stalled");

	// one request at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	// a resize starts a sweep that blocks requests
	a_resize_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)
		|=> !in_ready)
		else $error("request window open right after resize");

	// register writes take precedence over requests
	a_cfg_first: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !in_ready)
		else $error("request and register write taken together");

endmodule

bind clipped_rect_fill_engine_unit crfe_checker u_crfe_checker (.*);
